[design/ibfs_pkg.sv]
package ibfs_pkg;

  // register index width on the configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Q = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_EN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIN = 8'd3;

  // floor(2^31 / 255), quotient estimate is low by at most one
  localparam logic [31:0] RECIP_255 = 32'd8421504;
  localparam int RECIP_SHIFT = 31;
  // 255 * 131073: any scaled magnitude above this saturates anyway
  localparam logic [24:0] X_LIMIT = 25'd33423615;
  localparam logic [7:0] PT_BIAS = 8'd127;

  typedef struct packed {
    logic signed [8:0] vi;
    logic signed [8:0] vq;
    logic              mix;
  } ibfs_item_t;

  typedef struct packed {
    logic               invert_q;
    logic               shift_enable;
    logic signed [31:0] step_cos;
    logic signed [31:0] step_sin;
  } ibfs_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MIX0,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_MIX4,
    ST_ROT0,
    ST_ROT1,
    ST_ROT2,
    ST_ROT3,
    ST_DIVI_MUL,
    ST_DIVI_FIX,
    ST_DIVQ_MUL,
    ST_DIVQ_FIX,
    ST_NRM0,
    ST_NRM1,
    ST_NRM2,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_DONE,
    ST_OUT
  } ibfs_state_t;

endpackage

[design/ibfs_if.sv]
interface ibfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] i_byte;
  logic [7:0] q_byte;
  modport source(output valid, i_byte, q_byte, input ready);
  modport sink(input valid, i_byte, q_byte, output ready);
endinterface

interface ibfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] out_i;
  logic signed [17:0] out_q;
  modport source(output valid, out_i, out_q, input ready);
  modport sink(input valid, out_i, out_q, output ready);
endinterface

[design/ibfs_front.sv]
module ibfs_front (
  ibfs_in_if.sink          in_bus,
  input  ibfs_pkg::ibfs_cfg_t  cfg,
  output logic             push_valid,
  input  logic             push_ready,
  output ibfs_pkg::ibfs_item_t push_item
);
  import ibfs_pkg::*;

  logic signed [8:0] vi;
  logic signed [8:0] vq_raw;

  // 2b - 255 is {b, 1} - 256: flip the top bit
  assign vi     = {~in_bus.i_byte[7], in_bus.i_byte[6:0], 1'b1};
  assign vq_raw = {~in_bus.q_byte[7], in_bus.q_byte[6:0], 1'b1};

  always_comb begin
    push_item.vi  = vi;
    push_item.vq  = cfg.invert_q ? -vq_raw : vq_raw;
    push_item.mix = cfg.shift_enable;
  end

  assign push_valid   = in_bus.valid;
  assign in_bus.ready = push_ready;

endmodule

[design/ibfs_fifo.sv]
module ibfs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  ibfs_pkg::ibfs_item_t push_item,
  output logic             pop_valid,
  input  logic             pop,
  output ibfs_pkg::ibfs_item_t pop_item
);
  import ibfs_pkg::*;

  ibfs_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/ibfs_back.sv]
module ibfs_back #(
  parameter int RENORM_INTERVAL_LOG2 = 12,
  parameter int OSC_FRACTION_BITS    = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ibfs_pkg::ibfs_cfg_t  cfg,
  input  logic             restart,
  input  logic             pop_valid,
  output logic             pop,
  input  ibfs_pkg::ibfs_item_t pop_item,
  ibfs_out_if.source       out_bus
);
  import ibfs_pkg::*;

  localparam logic signed [31:0] OSC_ONE = 32'(64'(1) << OSC_FRACTION_BITS);
  localparam logic signed [64:0] ROT_HALF = 65'(65'(1) << (OSC_FRACTION_BITS - 1));

  ibfs_state_t state_r, state_nxt;

  logic signed [31:0] osc_re_r, osc_im_r;
  logic [RENORM_INTERVAL_LOG2-1:0] cnt_r;
  ibfs_item_t         ent_r;
  logic signed [63:0] prod_r;
  logic signed [64:0] acc_r;
  logic signed [41:0] di_r, dq_r;
  logic signed [31:0] nr_r;
  logic               renorm_r;
  logic [24:0]        x_r;
  logic signed [17:0] res_i_r, res_q_r;
  logic [63:0]        sq_x_r, sq_res_r, sq_bit_r;
  logic [4:0]         it_r;
  logic [31:0]        rem_r, dn_r, quo_r;
  logic               dv_im_r;
  logic               out_valid_r;
  logic signed [17:0] out_i_r, out_q_r;

  logic signed [31:0] mul_a, mul_b;
  logic [24:0]        x_cur;
  logic signed [17:0] fix_res;
  logic [63:0]        sq_sum;
  logic [31:0]        mag;
  logic signed [31:0] div_c;
  logic [31:0]        div_cm;
  logic [63:0]        div_n;
  logic [32:0]        div_t;
  logic               out_free;

  function automatic logic [24:0] x_of(input logic signed [41:0] d, input logic mix);
    logic [41:0] mg;
    logic [59:0] a;
    logic [59:0] t;
    mg = d[41] ? 42'(-d) : 42'(d);
    if (mix) begin
      a = (60'(mg) << 16) + (60'(255) << (OSC_FRACTION_BITS - 1));
      t = a >> OSC_FRACTION_BITS;
    end else begin
      t = (60'(mg) << 16) + 60'(PT_BIAS);
    end
    if (t > 60'(X_LIMIT)) begin
      t = 60'(X_LIMIT);
    end
    return t[24:0];
  endfunction

  // finish x / 255 and apply sign with 18-bit saturation
  function automatic logic signed [17:0] fix_of(input logic [63:0] p, input logic [24:0] x,
                                                input logic neg);
    logic [17:0] q0;
    logic [26:0] rr;
    logic [17:0] q;
    q0 = p[RECIP_SHIFT+17:RECIP_SHIFT];
    rr = 27'(x) - (27'(q0) << 8) + 27'(q0);
    q  = (rr >= 27'd255) ? q0 + 18'd1 : q0;
    if (neg) begin
      return (q > 18'd131072) ? -18'sd131072 : 18'(-$signed({1'b0, q}));
    end
    return (q > 18'd131071) ? 18'sd131071 : $signed(q);
  endfunction

  function automatic logic signed [31:0] rot_sat(input logic signed [64:0] s);
    logic signed [64:0] r;
    r = (s + ROT_HALF) >>> OSC_FRACTION_BITS;
    if (r > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (r < -65'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(r);
  endfunction

  assign out_free = !out_valid_r || out_bus.ready;
  assign x_cur    = (state_r == ST_DIVQ_MUL) ? x_of(dq_r, ent_r.mix) : x_of(di_r, ent_r.mix);
  assign fix_res  = (state_r == ST_DIVQ_FIX) ? fix_of(prod_r, x_r, dq_r[41])
                                             : fix_of(prod_r, x_r, di_r[41]);
  assign sq_sum   = sq_res_r + sq_bit_r;
  assign mag      = sq_res_r[31:0];
  assign div_c    = dv_im_r ? osc_im_r : osc_re_r;
  assign div_cm   = div_c[31] ? 32'(-div_c) : 32'(div_c);
  assign div_n    = (64'(div_cm) << OSC_FRACTION_BITS) + 64'(mag >> 1);
  assign div_t    = {rem_r, dn_r[31]};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MIX0:     begin mul_a = 32'(ent_r.vi); mul_b = osc_re_r; end
      ST_MIX1:     begin mul_a = 32'(ent_r.vq); mul_b = osc_im_r; end
      ST_MIX2:     begin mul_a = 32'(ent_r.vi); mul_b = osc_im_r; end
      ST_MIX3:     begin mul_a = 32'(ent_r.vq); mul_b = osc_re_r; end
      ST_MIX4:     begin mul_a = osc_re_r; mul_b = cfg.step_cos; end
      ST_ROT0:     begin mul_a = osc_im_r; mul_b = cfg.step_sin; end
      ST_ROT1:     begin mul_a = osc_re_r; mul_b = cfg.step_sin; end
      ST_ROT2:     begin mul_a = osc_im_r; mul_b = cfg.step_cos; end
      ST_DIVI_MUL,
      ST_DIVQ_MUL: begin mul_a = $signed(32'(x_cur)); mul_b = $signed(RECIP_255); end
      ST_NRM0:     begin mul_a = osc_re_r; mul_b = osc_re_r; end
      ST_NRM1:     begin mul_a = osc_im_r; mul_b = osc_im_r; end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          pop       = 1'b1;
          state_nxt = pop_item.mix ? ST_MIX0 : ST_DIVI_MUL;
        end
      end
      ST_MIX0:     state_nxt = ST_MIX1;
      ST_MIX1:     state_nxt = ST_MIX2;
      ST_MIX2:     state_nxt = ST_MIX3;
      ST_MIX3:     state_nxt = ST_MIX4;
      ST_MIX4:     state_nxt = ST_ROT0;
      ST_ROT0:     state_nxt = ST_ROT1;
      ST_ROT1:     state_nxt = ST_ROT2;
      ST_ROT2:     state_nxt = ST_ROT3;
      ST_ROT3:     state_nxt = ST_DIVI_MUL;
      ST_DIVI_MUL: state_nxt = ST_DIVI_FIX;
      ST_DIVI_FIX: state_nxt = ST_DIVQ_MUL;
      ST_DIVQ_MUL: state_nxt = ST_DIVQ_FIX;
      ST_DIVQ_FIX: state_nxt = (ent_r.mix && renorm_r) ? ST_NRM0 : ST_OUT;
      ST_NRM0:     state_nxt = ST_NRM1;
      ST_NRM1:     state_nxt = ST_NRM2;
      ST_NRM2:     state_nxt = ST_SQRT;
      ST_SQRT:     state_nxt = (it_r == 5'd31) ? ST_DIV_INIT : ST_SQRT;
      ST_DIV_INIT: state_nxt = (mag == 32'd0) ? ST_OUT : ST_DIV;
      ST_DIV:      state_nxt = (it_r == 5'd31) ? ST_DIV_DONE : ST_DIV;
      ST_DIV_DONE: state_nxt = dv_im_r ? ST_OUT : ST_DIV_INIT;
      ST_OUT:      state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        ent_r <= pop_item;
        di_r  <= 42'(pop_item.vi);
        dq_r  <= 42'(pop_item.vq);
      end
      ST_MIX1:     acc_r <= 65'(prod_r);
      ST_MIX2:     di_r  <= 42'(acc_r - 65'(prod_r));
      ST_MIX3:     acc_r <= 65'(prod_r);
      ST_MIX4:     dq_r  <= 42'(acc_r + 65'(prod_r));
      ST_ROT0:     acc_r <= 65'(prod_r);
      ST_ROT1:     nr_r  <= rot_sat(acc_r - 65'(prod_r));
      ST_ROT2:     acc_r <= 65'(prod_r);
      ST_DIVI_MUL,
      ST_DIVQ_MUL: x_r <= x_cur;
      ST_DIVI_FIX: res_i_r <= fix_res;
      ST_DIVQ_FIX: res_q_r <= fix_res;
      ST_NRM1:     acc_r <= 65'(prod_r);
      ST_NRM2: begin
        sq_x_r   <= 64'(acc_r + 65'(prod_r));
        sq_res_r <= '0;
        sq_bit_r <= 64'(1) << 62;
        dv_im_r  <= 1'b0;
      end
      ST_SQRT: begin
        if (sq_x_r >= sq_sum) begin
          sq_x_r   <= sq_x_r - sq_sum;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_DIV_INIT: begin
        rem_r <= div_n[63:32];
        dn_r  <= div_n[31:0];
        quo_r <= '0;
      end
      ST_DIV: begin
        if (div_t >= 33'(mag)) begin
          rem_r <= 32'(div_t - 33'(mag));
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= div_t[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        dn_r <= dn_r << 1;
      end
      ST_DIV_DONE: dv_im_r <= 1'b1;
      default: begin
      end
    endcase
  end

  // iteration counter for root and divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (state_r == ST_SQRT || state_r == ST_DIV) begin
      it_r <= it_r + 5'd1;
    end else begin
      it_r <= '0;
    end
  end

  // oscillator state
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      osc_re_r <= OSC_ONE;
      osc_im_r <= '0;
      cnt_r    <= '0;
      renorm_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_ROT3: begin
          osc_re_r <= nr_r;
          osc_im_r <= rot_sat(acc_r + 65'(prod_r));
          cnt_r    <= cnt_r + 1'b1;
          renorm_r <= &cnt_r;
        end
        ST_DIV_DONE: begin
          if (dv_im_r) begin
            osc_im_r <= div_c[31] ? 32'(-quo_r) : quo_r;
          end else begin
            osc_re_r <= div_c[31] ? 32'(-quo_r) : quo_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_i_r <= res_i_r;
      out_q_r <= res_q_r;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.out_i = out_i_r;
  assign out_bus.out_q = out_q_r;

endmodule

[design/iq_byte_frequency_shifter.sv]
// channel   dir  beat payload                        handshake
// in_bus    in   i_byte[7:0], q_byte[7:0] unsigned   valid/ready
// out_bus   out  out_i[17:0], out_q[17:0] signed     valid/ready
// cfg_*     in   cfg_index, cfg_wdata[31:0]          cfg_we, no back-pressure
//
// in pass-through a beat takes the two divide-by-255 steps; with the mixer on it
// first mixes and rotates the oscillator, all through the single shared 32x32
// multiplier the back end steps through; on the renormalization beat come 32 root
// steps and two 32-step divides (skipped on zero magnitude), one bit per cycle
// reset is synchronous active-low; the oscillator restarts at (1, 0)
// the input takes beats into a 2-deep queue while the back end works or the
// output register waits on out_bus.ready
module iq_byte_frequency_shifter #(
  parameter int RENORM_INTERVAL_LOG2 = 12,
  parameter int OSC_FRACTION_BITS    = 30
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ibfs_in_if.sink                          in_bus,
  ibfs_out_if.source                       out_bus,
  input  logic                             cfg_we,
  input  logic [ibfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ibfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ibfs_pkg::*;

  localparam logic signed [31:0] STEP_ONE = 32'(64'(1) << OSC_FRACTION_BITS);

  ibfs_cfg_t  cfg_r;
  logic       cfg_hit;
  logic       push_valid;
  logic       push_ready;
  ibfs_item_t push_item;
  logic       pop_valid;
  logic       pop;
  ibfs_item_t pop_item;

  // any write to a known register also restarts the oscillator
  assign cfg_hit = cfg_we && (cfg_index == REG_INVERT_Q || cfg_index == REG_SHIFT_EN ||
                              cfg_index == REG_STEP_COS || cfg_index == REG_STEP_SIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_q     <= 1'b0;
      cfg_r.shift_enable <= 1'b0;
      cfg_r.step_cos     <= STEP_ONE;
      cfg_r.step_sin     <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_INVERT_Q: cfg_r.invert_q     <= cfg_wdata[0];
        REG_SHIFT_EN: cfg_r.shift_enable <= cfg_wdata[0];
        REG_STEP_COS: cfg_r.step_cos     <= $signed(cfg_wdata);
        REG_STEP_SIN: cfg_r.step_sin     <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // front: byte to signed value, q inversion, mode tag
  ibfs_front u_front (
    .in_bus     (in_bus),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ibfs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // back: mixer, oscillator rotation, renormalization, output register
  ibfs_back #(
    .RENORM_INTERVAL_LOG2 (RENORM_INTERVAL_LOG2),
    .OSC_FRACTION_BITS    (OSC_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .restart   (cfg_hit),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_bus   (out_bus)
  );

endmodule
